// File: hdl/dmrhd_pkg.sv
`timescale 1ns / 1ps

package dmrhd_pkg;

	// configuration register indexes
	localparam int CfgIdxW = 2;
	localparam int CfgDataW = 9;
	localparam logic [CfgIdxW-1:0] REG_SLEW_LIMIT   = 2'd0;
	localparam logic [CfgIdxW-1:0] REG_SPREAD_LIMIT = 2'd1;
	localparam logic [CfgIdxW-1:0] REG_INVERT_LEFT  = 2'd2;
	localparam logic [CfgIdxW-1:0] REG_INVERT_RIGHT = 2'd3;

	// reset values of the registers
	localparam logic [7:0] SLEW_LIMIT_RST   = 8'd14;
	localparam logic [8:0] SPREAD_LIMIT_RST = 9'd230;
	localparam logic       INVERT_LEFT_RST  = 1'b0;
	localparam logic       INVERT_RIGHT_RST = 1'b1;

	// command modes
	localparam logic ACT_SMOOTH = 1'b0;
	localparam logic ACT_RAW    = 1'b1;

	// speed limit of either side
	localparam logic signed [8:0] SPEED_MAX = 9'sd255;
	localparam logic signed [8:0] SPEED_MIN = -9'sd255;

	typedef struct packed {
		logic               action;
		logic signed [15:0] left_target;
		logic signed [15:0] right_target;
	} dmrhd_in_t;

	typedef struct packed {
		logic       left_dir_a;
		logic       left_dir_b;
		logic [7:0] left_duty;
		logic       right_dir_a;
		logic       right_dir_b;
		logic [7:0] right_duty;
	} dmrhd_out_t;

endpackage

// File: hdl/dual_motor_ramp_hbridge_drive.sv
`timescale 1ns / 1ps
// path: an accepted request is held in the input register, then in the result register
// throughput: one request per cycle while the receiver does not stall; the input register and the result register
// each hold one request, and a single pass of clamp/ramp logic sits between them
// reset: valid bits drop, stored speeds go to zero, registers take their reset values
// (slew limit 14, spread limit 230, invert_left 0, invert_right 1)

module dual_motor_ramp_hbridge_drive (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [dmrhd_pkg::CfgIdxW-1:0]      cfg_index,
	input  logic [dmrhd_pkg::CfgDataW-1:0]     cfg_data,
	input  logic                               in_valid,
	output logic                               in_stall,
	input  dmrhd_pkg::dmrhd_in_t               in_data,
	output logic                               out_valid,
	input  logic                               out_stall,
	output dmrhd_pkg::dmrhd_out_t              out_data
);
	import dmrhd_pkg::*;

	logic [7:0]          slew_limit_q;
	logic [8:0]          spread_limit_q;
	logic                invert_left_q;
	logic                invert_right_q;
	logic signed [8:0]   left_now_q;
	logic signed [8:0]   right_now_q;

	logic                valid_s1;
	dmrhd_in_t           data_s1;
	logic                out_valid_q;
	dmrhd_out_t          out_data_q;

	logic                advance;
	logic                move_s1;

	logic signed [8:0]   lt_c;
	logic signed [8:0]   rt_c;
	logic signed [10:0]  diff;
	logic signed [10:0]  dm;
	logic signed [9:0]   sum;
	logic signed [9:0]   sum_adj;
	logic signed [8:0]   mid;
	logic signed [10:0]  half;
	logic signed [10:0]  goal_l;
	logic signed [10:0]  goal_r;
	logic signed [8:0]   left_next;
	logic signed [8:0]   right_next;
	logic signed [16:0]  drive_l;
	logic signed [16:0]  drive_r;
	dmrhd_out_t          result;

	// clamp a wide signed value to the speed range
	function automatic logic signed [8:0] clamp_speed(input logic signed [16:0] v);
		if (v > 17'sd255) begin
			return SPEED_MAX;
		end else if (v < -17'sd255) begin
			return SPEED_MIN;
		end
		return v[8:0];
	endfunction

	// step the stored speed toward the goal by at most lim
	function automatic logic signed [8:0] move_toward(
		input logic signed [8:0]  now,
		input logic signed [10:0] goal,
		input logic [7:0]         lim
	);
		logic signed [10:0] now_w;
		logic signed [10:0] up;
		logic signed [10:0] dn;
		logic signed [10:0] res;
		now_w = 11'(now);
		up    = now_w + $signed({3'b000, lim});
		dn    = now_w - $signed({3'b000, lim});
		if (goal > now_w) begin
			res = (up < goal) ? up : goal;
		end else if (goal < now_w) begin
			res = (dn > goal) ? dn : goal;
		end else begin
			res = now_w;
		end
		return res[8:0];
	endfunction

	// invert, clamp and split into bridge pins and duty
	function automatic logic [9:0] drive_side(input logic signed [16:0] speed, input logic inv);
		logic signed [16:0] s;
		logic signed [8:0]  c;
		logic signed [8:0]  mag;
		s   = inv ? -speed : speed;
		c   = clamp_speed(s);
		mag = (c < 0) ? -c : c;
		return {c > 0, c < 0, mag[7:0]};
	endfunction

	// handshake: the input register moves on when the result register is free
	assign advance   = !out_valid_q || !out_stall;
	assign move_s1   = valid_s1 && advance;
	assign in_stall  = valid_s1 && !advance;
	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slew_limit_q   <= SLEW_LIMIT_RST;
			spread_limit_q <= SPREAD_LIMIT_RST;
			invert_left_q  <= INVERT_LEFT_RST;
			invert_right_q <= INVERT_RIGHT_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_SLEW_LIMIT:   slew_limit_q   <= cfg_data[7:0];
				REG_SPREAD_LIMIT: spread_limit_q <= cfg_data[8:0];
				REG_INVERT_LEFT:  invert_left_q  <= cfg_data[0];
				REG_INVERT_RIGHT: invert_right_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// smooth path: clamp, limit the left/right spread, ramp the stored speeds
	always_comb begin
		lt_c    = clamp_speed(17'(data_s1.left_target));
		rt_c    = clamp_speed(17'(data_s1.right_target));
		diff    = 11'(lt_c) - 11'(rt_c);
		dm      = $signed({2'b00, spread_limit_q});
		sum     = 10'(lt_c) + 10'(rt_c);
		// divide by two rounding toward zero
		sum_adj = sum + ((sum < 0) ? 10'sd1 : 10'sd0);
		mid     = 9'(sum_adj >>> 1);
		half    = $signed({3'b000, spread_limit_q[8:1]});
		if (diff > dm) begin
			goal_l = 11'(mid) + half;
			goal_r = 11'(mid) - half;
		end else if (diff < -dm) begin
			goal_l = 11'(mid) - half;
			goal_r = 11'(mid) + half;
		end else begin
			goal_l = 11'(lt_c);
			goal_r = 11'(rt_c);
		end
		left_next  = move_toward(left_now_q, goal_l, slew_limit_q);
		right_next = move_toward(right_now_q, goal_r, slew_limit_q);
	end

	// pick the driven speeds and form the bridge outputs
	always_comb begin
		if (data_s1.action == ACT_RAW) begin
			drive_l = 17'(data_s1.left_target);
			drive_r = 17'(data_s1.right_target);
		end else begin
			drive_l = 17'(left_next);
			drive_r = 17'(right_next);
		end
		{result.left_dir_a, result.left_dir_b, result.left_duty} =
			drive_side(drive_l, invert_left_q);
		{result.right_dir_a, result.right_dir_b, result.right_duty} =
			drive_side(drive_r, invert_right_q);
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!valid_s1 || advance) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			data_s1 <= in_data;
		end
	end

	// stored speeds follow each smooth request as it leaves the input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_now_q  <= '0;
			right_now_q <= '0;
		end else if (move_s1 && data_s1.action == ACT_SMOOTH) begin
			left_now_q  <= left_next;
			right_now_q <= right_next;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (move_s1) begin
			out_data_q <= result;
		end
	end

`ifndef NO_ASSERTIONS
	// a bridge is never driven both ways at once
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> !(out_data_q.left_dir_a && out_data_q.left_dir_b)
			&& !(out_data_q.right_dir_a && out_data_q.right_dir_b))
		else $error("bridge pins both high");

	// left pins low exactly when left duty is zero
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> ((out_data_q.left_duty == 8'd0) ==
			!(out_data_q.left_dir_a || out_data_q.left_dir_b)))
		else $error("left duty and pins disagree");

	// stored speeds stay inside the speed range
	assert property (@(posedge clk) disable iff (!arst_n)
		left_now_q <= SPEED_MAX && left_now_q >= SPEED_MIN
			&& right_now_q <= SPEED_MAX && right_now_q >= SPEED_MIN)
		else $error("stored speed out of range");

	// a smooth request changes the left stored speed by at most the slew limit
	assert property (@(posedge clk) disable iff (!arst_n)
		(move_s1 && data_s1.action == ACT_SMOOTH) |=>
			((11'(left_now_q) - 11'($past(left_now_q))
				<= $signed({3'b000, $past(slew_limit_q)}))
			&& (11'($past(left_now_q)) - 11'(left_now_q)
				<= $signed({3'b000, $past(slew_limit_q)}))))
		else $error("left speed stepped too far");

	// raw requests, stalls and idle cycles leave the stored speeds alone
	assert property (@(posedge clk) disable iff (!arst_n)
		!(move_s1 && data_s1.action == ACT_SMOOTH) |=>
			$stable(left_now_q) && $stable(right_now_q))
		else $error("stored speed changed without a smooth request");
`endif

endmodule

// File: tb/sv/tb_dual_motor_ramp_hbridge_drive.sv
`timescale 1ns / 1ps

module tb_dual_motor_ramp_hbridge_drive;
	import dmrhd_pkg::*;

	logic                clk;
	logic                arst_n;
	logic                cfg_we;
	logic [CfgIdxW-1:0]  cfg_index;
	logic [CfgDataW-1:0] cfg_data;
	logic                in_valid;
	logic                in_stall;
	dmrhd_in_t           in_data;
	logic                out_valid;
	logic                out_stall;
	dmrhd_out_t          out_data;

	dual_motor_ramp_hbridge_drive u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

	// one row of the directed command table
	typedef struct packed {
		bit                  is_cfg;
		logic [CfgIdxW-1:0]  idx;
		logic [CfgDataW-1:0] val;
		dmrhd_in_t           req;
		bit                  typed;
		dmrhd_out_t          want;
	} drive_row_t;

	drive_row_t stim_rows[$];
	dmrhd_out_t drive_due[$];
	dmrhd_out_t want_now;

	// mirror of the drive registers and of the stored speeds
	bit [7:0]         ramp_m;
	bit [8:0]         diff_m;
	bit               inv_l_m;
	bit               inv_r_m;
	logic signed [8:0] left_now;
	logic signed [8:0] right_now;

	bit calm;
	int faults;
	int results_seen;
	int hold_left;
	int hold_at;

	// 50 MHz clock
	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	function automatic int clamp_speed(input int v);
		if (v > 255) return 255;
		if (v < -255) return -255;
		return v;
	endfunction

	function automatic int step_toward(input int now, input int goal, input int lim);
		if (goal > now) return (now + lim < goal) ? now + lim : goal;
		if (goal < now) return (now - lim > goal) ? now - lim : goal;
		return now;
	endfunction

	// pins a, b and duty of one bridge
	function automatic logic [9:0] bridge_side(input int speed, input bit inv);
		int s;
		s = inv ? -speed : speed;
		s = clamp_speed(s);
		return {s > 0, s < 0, 8'(s < 0 ? -s : s)};
	endfunction

	// expected bridge drive for one command; a smooth command advances the stored speeds
	function automatic dmrhd_out_t predict_drive(input dmrhd_in_t req);
		int lt, rt, dm, half, mid;
		dmrhd_out_t res;
		lt = $signed(req.left_target);
		rt = $signed(req.right_target);
		if (req.action == ACT_SMOOTH) begin
			dm = diff_m;
			half = dm / 2;
			lt = clamp_speed(lt);
			rt = clamp_speed(rt);
			// pull both targets toward their midpoint when too far apart
			if (lt - rt > dm) begin
				mid = (lt + rt) / 2;
				lt = mid + half;
				rt = mid - half;
			end else if (lt - rt < -dm) begin
				mid = (lt + rt) / 2;
				lt = mid - half;
				rt = mid + half;
			end
			left_now = 9'(step_toward(left_now, lt, ramp_m));
			right_now = 9'(step_toward(right_now, rt, ramp_m));
			lt = left_now;
			rt = right_now;
		end
		{res.left_dir_a, res.left_dir_b, res.left_duty} = bridge_side(lt, inv_l_m);
		{res.right_dir_a, res.right_dir_b, res.right_duty} = bridge_side(rt, inv_r_m);
		return res;
	endfunction

	function automatic void add_cfg(input logic [CfgIdxW-1:0] idx,
			input logic [CfgDataW-1:0] val);
		drive_row_t r;
		r = '0;
		r.is_cfg = 1'b1;
		r.idx = idx;
		r.val = val;
		stim_rows.push_back(r);
	endfunction

	function automatic void add_req(input logic act, input logic signed [15:0] l,
			input logic signed [15:0] r);
		drive_row_t row;
		row = '0;
		row.req = '{act, l, r};
		stim_rows.push_back(row);
	endfunction

	function automatic void add_typed(input logic act, input logic signed [15:0] l,
			input logic signed [15:0] r, input dmrhd_out_t want);
		drive_row_t row;
		row = '0;
		row.req = '{act, l, r};
		row.typed = 1'b1;
		row.want = want;
		stim_rows.push_back(row);
	endfunction

	function automatic logic signed [15:0] rand_target();
		case ($urandom_range(0, 9))
			0: return 16'($urandom);
			1: begin
				case ($urandom_range(0, 8))
					0: return -16'sd32768;
					1: return 16'sd32767;
					2: return -16'sd256;
					3: return 16'sd256;
					4: return -16'sd255;
					5: return 16'sd255;
					6: return 16'sd1;
					7: return -16'sd1;
					default: return 16'sd0;
				endcase
			end
			default: return 16'($signed($urandom_range(0, 620)) - 310);
		endcase
	endfunction

	// register write; leaves cfg_we high, the caller drops it
	task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		case (idx)
			REG_SLEW_LIMIT:   ramp_m = val[7:0];
			REG_SPREAD_LIMIT: diff_m = val;
			REG_INVERT_LEFT:  inv_l_m = val[0];
			default:          inv_r_m = val[0];
		endcase
		@(negedge clk);
	endtask

	// stop offering and let every pending request come out
	task automatic drain();
		in_valid <= 1'b0;
		while (drive_due.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	// offer one request; entered and left at a falling edge
	task automatic push_request(input dmrhd_in_t req, input bit typed, input dmrhd_out_t want);
		dmrhd_out_t got;
		while (!calm && $urandom_range(0, 99) < 14) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		in_data <= req;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		got = predict_drive(req);
		drive_due.push_back(typed ? want : got);
		@(negedge clk);
	endtask

	task automatic check_field(input string what, input int want, input int got);
		if (want != got) begin
			faults++;
			$display("%0t mismatch %s expected %0d actual %0d", $time, what, want, got);
		end
	endtask

	// result checker
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			results_seen++;
			if (drive_due.size() == 0) begin
				faults++;
				$display("%0t unexpected result expected none actual %h", $time, out_data);
			end else begin
				want_now = drive_due.pop_front();
				check_field("left_dir_a", want_now.left_dir_a, out_data.left_dir_a);
				check_field("left_dir_b", want_now.left_dir_b, out_data.left_dir_b);
				check_field("left_duty", want_now.left_duty, out_data.left_duty);
				check_field("right_dir_a", want_now.right_dir_a, out_data.right_dir_a);
				check_field("right_dir_b", want_now.right_dir_b, out_data.right_dir_b);
				check_field("right_duty", want_now.right_duty, out_data.right_duty);
			end
		end
	end

	// receiver: random stalls plus a few long hold-offs
	initial begin
		out_stall = 1'b0;
		hold_left = 0;
		hold_at = 100;
		forever begin
			@(negedge clk);
			if (!calm && hold_left == 0 && results_seen >= hold_at) begin
				hold_left = 60;
				hold_at += 300;
			end
			if (hold_left > 0) begin
				out_stall <= 1'b1;
				hold_left--;
			end else begin
				out_stall <= (!calm && $urandom_range(0, 99) < 14);
			end
		end
	end

	// run limit
	initial begin
		#2_000_000;
		$display("RESULT: ERROR");
		$finish;
	end

	// stimulus
	initial begin
		dmrhd_in_t req;
		logic signed [15:0] l_tgt, r_tgt;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		in_valid = 1'b0;
		in_data = '0;
		arst_n = 1'b0;
		calm = 1'b0;
		faults = 0;
		results_seen = 0;
		ramp_m = SLEW_LIMIT_RST;
		diff_m = SPREAD_LIMIT_RST;
		inv_l_m = INVERT_LEFT_RST;
		inv_r_m = INVERT_RIGHT_RST;
		left_now = '0;
		right_now = '0;

		// raw extremes and the first smooth step out of reset
		add_typed(ACT_RAW, 0, 0, dmrhd_out_t'{1'b0, 1'b0, 8'd0, 1'b0, 1'b0, 8'd0});
		add_typed(ACT_RAW, 32767, -32768,
			dmrhd_out_t'{1'b1, 1'b0, 8'd255, 1'b1, 1'b0, 8'd255});
		add_typed(ACT_RAW, -32768, 32767,
			dmrhd_out_t'{1'b0, 1'b1, 8'd255, 1'b0, 1'b1, 8'd255});
		add_typed(ACT_RAW, 100, -7, dmrhd_out_t'{1'b1, 1'b0, 8'd100, 1'b1, 1'b0, 8'd7});
		add_typed(ACT_SMOOTH, 255, 255, dmrhd_out_t'{1'b1, 1'b0, 8'd14, 1'b0, 1'b1, 8'd14});
		// difference limit with even and odd sums
		add_req(ACT_SMOOTH, 1000, -1000);
		add_req(ACT_SMOOTH, -300, 301);
		add_req(ACT_SMOOTH, 255, -20);
		add_req(ACT_SMOOTH, -255, 20);
		// full-scale step
		add_cfg(REG_SLEW_LIMIT, 9'd255);
		add_req(ACT_SMOOTH, -255, 255);
		add_req(ACT_SMOOTH, 255, -255);
		// zero step holds the speeds
		add_cfg(REG_SLEW_LIMIT, 9'd0);
		add_req(ACT_SMOOTH, 200, -200);
		add_typed(ACT_RAW, 255, -255, dmrhd_out_t'{1'b1, 1'b0, 8'd255, 1'b1, 1'b0, 8'd255});
		// zero difference limit collapses both targets to the midpoint
		add_cfg(REG_SLEW_LIMIT, 9'd9);
		add_cfg(REG_SPREAD_LIMIT, 9'd0);
		add_req(ACT_SMOOTH, 100, -51);
		add_req(ACT_SMOOTH, -3, 2);
		// widest difference limit never recenters
		add_cfg(REG_SPREAD_LIMIT, 9'd511);
		add_req(ACT_SMOOTH, 255, -255);
		add_req(ACT_SMOOTH, -256, 256);
		// swapped inversion
		add_cfg(REG_INVERT_LEFT, 9'd1);
		add_cfg(REG_INVERT_RIGHT, 9'd0);
		add_typed(ACT_RAW, -32768, -32768,
			dmrhd_out_t'{1'b1, 1'b0, 8'd255, 1'b0, 1'b1, 8'd255});
		add_typed(ACT_RAW, 1, -1, dmrhd_out_t'{1'b0, 1'b1, 8'd1, 1'b0, 1'b1, 8'd1});
		add_req(ACT_SMOOTH, 255, 255);
		add_cfg(REG_SLEW_LIMIT, 9'd1);
		add_cfg(REG_SPREAD_LIMIT, 9'd1);
		add_req(ACT_SMOOTH, 50, 40);
		add_req(ACT_SMOOTH, 40, 50);

		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed table
		foreach (stim_rows[i]) begin
			if (stim_rows[i].is_cfg) begin
				if (i == 0 || !stim_rows[i-1].is_cfg)
					drain();
				write_reg(stim_rows[i].idx, stim_rows[i].val);
				if (i == stim_rows.size() - 1 || !stim_rows[i+1].is_cfg)
					cfg_we <= 1'b0;
			end else begin
				push_request(stim_rows[i].req, stim_rows[i].typed, stim_rows[i].want);
			end
		end

		// random phases, each under its own register setting
		l_tgt = '0;
		r_tgt = '0;
		for (int ph = 0; ph < 6; ph++) begin
			drain();
			case (ph)
				0: begin
					write_reg(REG_SLEW_LIMIT, 9'd255);
					write_reg(REG_SPREAD_LIMIT, 9'd0);
					write_reg(REG_INVERT_LEFT, 9'd1);
					write_reg(REG_INVERT_RIGHT, 9'd1);
				end
				1: begin
					write_reg(REG_SLEW_LIMIT, 9'd1);
					write_reg(REG_SPREAD_LIMIT, 9'd511);
					write_reg(REG_INVERT_LEFT, 9'd0);
					write_reg(REG_INVERT_RIGHT, 9'd0);
				end
				2: begin
					write_reg(REG_SLEW_LIMIT, 9'd0);
					write_reg(REG_SPREAD_LIMIT, 9'd510);
					write_reg(REG_INVERT_LEFT, {8'($urandom), 1'b0});
					write_reg(REG_INVERT_RIGHT, {8'($urandom), 1'b1});
				end
				default: begin
					write_reg(REG_SLEW_LIMIT, 9'($urandom_range(0, 255)));
					write_reg(REG_SPREAD_LIMIT, 9'($urandom_range(0, 511)));
					write_reg(REG_INVERT_LEFT, 9'($urandom));
					write_reg(REG_INVERT_RIGHT, 9'($urandom));
				end
			endcase
			cfg_we <= 1'b0;
			// one phase runs back to back on both sides
			calm = (ph == 2);
			for (int n = 0; n < 100; n++) begin
				// often hold the targets so the ramp can settle
				if ($urandom_range(0, 99) >= 40) begin
					l_tgt = rand_target();
					r_tgt = rand_target();
				end
				req.action = ($urandom_range(0, 3) == 0) ? ACT_RAW : ACT_SMOOTH;
				req.left_target = l_tgt;
				req.right_target = r_tgt;
				push_request(req, 1'b0, '0);
			end
			calm = 1'b0;
		end

		in_valid <= 1'b0;
		while (drive_due.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		if (faults == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
